FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RLID_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RLID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rlid_pkg.sv
package rlid_pkg;

  // palette size and narrowest accepted picture
  localparam int PALETTE_ENTRIES = 256;
  localparam int MIN_WIDTH       = 128;

  // byte counter covers the header text and the palette entry number
  localparam int IDX_W = ($clog2(PALETTE_ENTRIES) > 4) ? $clog2(PALETTE_ENTRIES) : 4;

  // header text lengths
  localparam int SIG_LEN   = 9;
  localparam int MAGIC_LEN = 12;

  // cursor row stops counting here
  localparam logic [12:0] ROW_LIMIT = 13'd4096;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_VER,
    PH_SIZE,
    PH_COLORS,
    PH_PAL,
    PH_DATA,
    PH_DEAD
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EOS_ERR,
    ST_LIT1,
    ST_LIT2,
    ST_RUN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    KIND_SIZE  = 2'd0,
    KIND_PAL   = 2'd1,
    KIND_SPAN  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SIG    = 2'd0,
    ERR_VER    = 2'd1,
    ERR_EOS    = 2'd2,
    ERR_NARROW = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    SRC_LIT1,
    SRC_LIT2,
    SRC_RUN
  } span_src_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      exec;
    logic      lit_step;
    logic      run_step;
    logic      rearm;
    logic      emit;
    kind_t     emit_kind;
    err_t      emit_err;
    logic      emit_last;
    span_src_t span_src;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    phase_t phase;
    logic   last;
    logic   sig_ok;
    logic   held_full;
    logic   narrow;
    logic   pal_final;
    logic   literal;
    logic   out_free;
    logic   span_vis;
    logic   lit_more;
    logic   run_wrap;
    logic   run_more;
    logic   run_nonzero;
  } dp_status_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] col_pos;
    logic [11:0] row_pos;
    logic [11:0] span_length;
    logic [10:0] pixel_color;
    logic [7:0]  entry_index;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  // expected header text, signature then version
  function automatic logic [7:0] magic_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h50;
      4'd1:    c = 8'h41;
      4'd2:    c = 8'h49;
      4'd3:    c = 8'h4E;
      4'd4:    c = 8'h54;
      4'd5:    c = 8'h50;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h4F;
      4'd8:    c = 8'h56;
      4'd9:    c = 8'h36;
      4'd10:   c = 8'h2E;
      4'd11:   c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/rlid_stream_if.sv
// byte stream channel
interface rlid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

// result channel
interface rlid_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] col_pos;
  logic [11:0] row_pos;
  logic [11:0] span_length;
  logic [10:0] pixel_color;
  logic [7:0]  entry_index;
  logic [7:0]  red_level;
  logic [7:0]  green_level;
  logic [7:0]  blue_level;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, kind, col_pos, row_pos, span_length, pixel_color,
                  entry_index, red_level, green_level, blue_level, error_code,
                  last_of_run, input ready);
  modport sink (input valid, kind, col_pos, row_pos, span_length, pixel_color,
                entry_index, red_level, green_level, blue_level, error_code,
                last_of_run, output ready);
endinterface

FILE: rtl/rlid_dp.sv
module rlid_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_stream,
  input  rlid_pkg::dp_cmd_t    cmd,
  output rlid_pkg::dp_status_t status,
  rlid_out_if.source           result
);
  import rlid_pkg::*;

  phase_t           phase;
  logic [IDX_W-1:0] byte_index;
  logic [15:0]      held_bytes;
  logic [1:0]       held_count;
  logic [11:0]      last_column;
  logic [11:0]      last_row;
  logic [11:0]      cursor_col;
  logic [12:0]      cursor_row;

  logic [7:0]  byte_q;
  logic        last_q;
  logic [11:0] grp_v1;
  logic [11:0] grp_v2;
  logic [11:0] run_left;

  logic        out_valid;
  result_t     out_q;
  result_t     res;

  logic [11:0] v1_now;
  logic [11:0] v2_now;
  logic        held_full;
  logic        sig_ok;
  logic        narrow;
  logic [12:0] lr13;
  logic [12:0] lc13;
  logic [12:0] width13;
  logic [12:0] row_inc;
  logic [12:0] col_inc;
  logic        lit_wrap;
  logic [12:0] col_sum_run;
  logic        run_wrap;
  logic [11:0] run_len_wrap;
  logic [15:0] held_shift;

  // group and header fields from the held bytes and the current byte
  assign v1_now     = held_bytes[15:4];
  assign v2_now     = {held_bytes[3:0], byte_q};
  assign held_full  = (held_count == 2'd2);
  assign held_shift = {held_bytes[7:0], byte_q};
  assign sig_ok     = (byte_q == magic_char(byte_index[3:0]));
  assign narrow     = (({1'b0, v1_now} + 13'd1) < 13'(MIN_WIDTH));

  // cursor arithmetic
  assign lr13         = {1'b0, last_row};
  assign lc13         = {1'b0, last_column};
  assign width13      = lc13 + 13'd1;
  assign row_inc      = (cursor_row < ROW_LIMIT) ? (cursor_row + 13'd1) : cursor_row;
  assign col_inc      = {1'b0, cursor_col} + 13'd1;
  assign lit_wrap     = (col_inc > lc13);
  assign col_sum_run  = {1'b0, cursor_col} + {1'b0, run_left};
  assign run_wrap     = (col_sum_run > lc13);
  assign run_len_wrap = 12'(width13 - {1'b0, cursor_col});

  // status toward the controller
  always_comb begin
    status             = '0;
    status.phase       = phase;
    status.last        = last_q;
    status.sig_ok      = sig_ok;
    status.held_full   = held_full;
    status.narrow      = narrow;
    status.pal_final   = (byte_index == IDX_W'(PALETTE_ENTRIES - 1));
    status.literal     = held_bytes[15];
    status.out_free    = !out_valid || result.ready;
    status.span_vis    = (cursor_row <= lr13);
    status.lit_more    = lit_wrap ? ((cursor_row + 13'd1) <= lr13) : (cursor_row <= lr13);
    status.run_wrap    = run_wrap;
    status.run_more    = (col_sum_run != width13) && ((cursor_row + 13'd1) <= lr13);
    status.run_nonzero = (run_left != 12'd0);
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst || cmd.rearm) begin
      phase       <= PH_SIG;
      byte_index  <= '0;
      held_bytes  <= '0;
      held_count  <= '0;
      last_column <= '0;
      last_row    <= '0;
      cursor_col  <= '0;
      cursor_row  <= '0;
    end else begin
      if (cmd.exec) begin
        case (phase)
          PH_SIG, PH_VER: begin
            if (sig_ok) begin
              if (byte_index == IDX_W'(MAGIC_LEN - 1)) begin
                phase      <= PH_SIZE;
                byte_index <= '0;
              end else begin
                byte_index <= byte_index + IDX_W'(1);
                if (byte_index == IDX_W'(SIG_LEN - 1)) phase <= PH_VER;
              end
            end else begin
              phase <= PH_DEAD;
            end
          end
          PH_SIZE, PH_COLORS: begin
            if (!held_full) begin
              held_bytes <= held_shift;
              held_count <= held_count + 2'd1;
            end else begin
              held_count <= '0;
              if (!last_q) begin
                if (phase == PH_SIZE) begin
                  last_column <= v1_now;
                  last_row    <= v2_now;
                  phase       <= narrow ? PH_DEAD : PH_COLORS;
                end else begin
                  phase      <= PH_PAL;
                  byte_index <= '0;
                end
              end
            end
          end
          PH_PAL: begin
            if (!held_full) begin
              held_bytes <= held_shift;
              held_count <= held_count + 2'd1;
            end else begin
              held_count <= '0;
              if (byte_index == IDX_W'(PALETTE_ENTRIES - 1)) begin
                phase      <= PH_DATA;
                byte_index <= '0;
                cursor_col <= '0;
                cursor_row <= '0;
              end else begin
                byte_index <= byte_index + IDX_W'(1);
              end
            end
          end
          PH_DATA: begin
            if (!held_full) begin
              held_bytes <= held_shift;
              held_count <= held_count + 2'd1;
            end else begin
              held_count <= '0;
            end
          end
          default: ;
        endcase
      end

      // one literal pixel
      if (cmd.lit_step) begin
        if (lit_wrap) begin
          cursor_col <= '0;
          cursor_row <= row_inc;
        end else begin
          cursor_col <= col_inc[11:0];
        end
      end

      // one span of a run
      if (cmd.run_step) begin
        if (run_wrap) begin
          cursor_col <= '0;
          cursor_row <= row_inc;
        end else begin
          cursor_col <= col_sum_run[11:0];
        end
      end
    end
  end

  // byte and group holding registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= data_byte;
      last_q <= end_of_stream;
    end
    if (cmd.exec && (phase == PH_DATA) && held_full) begin
      grp_v1   <= v1_now;
      grp_v2   <= v2_now;
      run_left <= v2_now;
    end else if (cmd.run_step && run_wrap) begin
      run_left <= run_left - run_len_wrap;
    end
  end

  // result selection
  always_comb begin
    res             = '0;
    res.kind        = cmd.emit_kind;
    res.last_of_run = cmd.emit_last;
    case (cmd.emit_kind)
      KIND_SIZE: begin
        res.col_pos = v1_now;
        res.row_pos = v2_now;
      end
      KIND_PAL: begin
        res.entry_index = 8'(byte_index);
        res.red_level   = held_bytes[15:8];
        res.green_level = held_bytes[7:0];
        res.blue_level  = byte_q;
      end
      KIND_SPAN: begin
        res.col_pos = cursor_col;
        res.row_pos = cursor_row[11:0];
        case (cmd.span_src)
          SRC_LIT1: begin
            res.span_length = 12'd1;
            res.pixel_color = grp_v1[10:0];
          end
          SRC_LIT2: begin
            res.span_length = 12'd1;
            res.pixel_color = grp_v2[10:0];
          end
          SRC_RUN: begin
            res.span_length = run_wrap ? run_len_wrap : run_left;
            res.pixel_color = grp_v1[10:0];
          end
          default: ;
        endcase
      end
      KIND_ERROR: res.error_code = cmd.emit_err;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_q <= res;
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_q.kind;
  assign result.col_pos     = out_q.col_pos;
  assign result.row_pos     = out_q.row_pos;
  assign result.span_length = out_q.span_length;
  assign result.pixel_color = out_q.pixel_color;
  assign result.entry_index = out_q.entry_index;
  assign result.red_level   = out_q.red_level;
  assign result.green_level = out_q.green_level;
  assign result.blue_level  = out_q.blue_level;
  assign result.error_code  = out_q.error_code;
  assign result.last_of_run = out_q.last_of_run;

endmodule

FILE: rtl/rlid_ctrl.sv
module rlid_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rlid_pkg::dp_status_t status,
  output rlid_pkg::dp_cmd_t    cmd
);
  import rlid_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    logic        emit_req;
    logic        finish;
    logic        go;
    ctrl_state_t target;

    emit_req   = 1'b0;
    finish     = 1'b0;
    target     = state;
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;

    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          target   = ST_EXEC;
        end
      end

      // per-byte decode step
      ST_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.emit_kind  = KIND_ERROR;
        cmd.emit_err   = ERR_EOS;
        cmd.emit_last  = 1'b1;
        finish         = 1'b1;
        case (status.phase)
          PH_SIG, PH_VER: begin
            if (!status.sig_ok) begin
              emit_req     = 1'b1;
              cmd.emit_err = (status.phase == PH_SIG) ? ERR_SIG : ERR_VER;
            end else begin
              emit_req = status.last;
            end
          end
          PH_SIZE, PH_COLORS: begin
            if (!status.held_full || status.last) begin
              emit_req = status.last;
            end else if (status.phase == PH_SIZE) begin
              emit_req = 1'b1;
              if (status.narrow) begin
                cmd.emit_err = ERR_NARROW;
              end else begin
                cmd.emit_kind = KIND_SIZE;
              end
            end
          end
          PH_PAL: begin
            if (!status.held_full) begin
              emit_req = status.last;
            end else begin
              emit_req      = 1'b1;
              cmd.emit_kind = KIND_PAL;
              if (!status.pal_final && status.last) begin
                cmd.emit_last = 1'b0;
                finish        = 1'b0;
                target        = ST_EOS_ERR;
              end
            end
          end
          PH_DATA: begin
            if (status.held_full) begin
              finish = 1'b0;
              target = status.literal ? ST_LIT1 : ST_RUN;
            end
          end
          default: ;
        endcase
      end

      // early end after a palette entry
      ST_EOS_ERR: begin
        emit_req      = 1'b1;
        cmd.emit_kind = KIND_ERROR;
        cmd.emit_err  = ERR_EOS;
        cmd.emit_last = 1'b1;
        finish        = 1'b1;
      end

      // first literal pixel of a group
      ST_LIT1: begin
        emit_req      = status.span_vis;
        cmd.emit_kind = KIND_SPAN;
        cmd.span_src  = SRC_LIT1;
        cmd.emit_last = !status.lit_more;
        cmd.lit_step  = 1'b1;
        target        = ST_LIT2;
      end

      // second literal pixel of a group
      ST_LIT2: begin
        emit_req      = status.span_vis;
        cmd.emit_kind = KIND_SPAN;
        cmd.span_src  = SRC_LIT2;
        cmd.emit_last = 1'b1;
        cmd.lit_step  = 1'b1;
        finish        = 1'b1;
      end

      // one span per cycle while the output register has room, until the run stays on its row
      ST_RUN: begin
        emit_req      = status.span_vis && (status.run_wrap || status.run_nonzero);
        cmd.emit_kind = KIND_SPAN;
        cmd.span_src  = SRC_RUN;
        cmd.emit_last = status.run_wrap ? !status.run_more : 1'b1;
        cmd.run_step  = 1'b1;
        finish        = !status.run_wrap;
      end

      default: target = ST_IDLE;
    endcase

    // hold everything while a result cannot be placed
    go       = !emit_req || status.out_free;
    cmd.emit = emit_req && go;
    if (!go) begin
      cmd.exec     = 1'b0;
      cmd.lit_step = 1'b0;
      cmd.run_step = 1'b0;
    end else if (finish) begin
      state_next = ST_IDLE;
      cmd.rearm  = status.last;
    end else begin
      state_next = target;
    end
  end

endmodule

FILE: rtl/rle_image_stream_decoder_unit.sv
// channel  modport  payload                                    role
// stream   sink     data_byte, end_of_stream                   file bytes in
// result   source   kind, col_pos, row_pos, span_length,       decoded results out
//                   pixel_color, entry_index, red/green/blue,
//                   error_code, last_of_run
//
// A byte is first taken into the byte register, then decoded in a controller step.
// A literal group then steps through its two pixels in turn; a run steps once per row end
// it crosses, plus once for its tail. An early end inside the palette after a full entry adds an error step.
// rst is synchronous: controller to idle, decoder to signature phase, output empty.
// Results wait in a one-entry output register; the controller holds while it is full
// and not being read.

`include "assert_macros.svh"

module rle_image_stream_decoder_unit (
  input logic         clk,
  input logic         rst,
  rlid_in_if.sink     stream,
  rlid_out_if.source  result
);
  import rlid_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign stream.ready = in_ready;

  // sequencing
  rlid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // decode state, cursor and output register
  rlid_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (stream.data_byte),
    .end_of_stream (stream.end_of_stream),
    .cmd           (cmd),
    .status        (status),
    .result        (result)
  );

  // checks
  `RLID_ASSERT_NEXT(a_busy_after_transfer, clk, rst, stream.valid && stream.ready, !stream.ready, "byte taken while previous byte still decoding")
  `RLID_ASSERT_SAME(a_emit_has_room, clk, rst, cmd.emit, !result.valid || result.ready, "result written over a pending result")
  `RLID_ASSERT_SAME(a_span_visible, clk, rst, cmd.emit && cmd.emit_kind == KIND_SPAN, status.span_vis, "span emitted below the last row")
  `RLID_ASSERT_NEXT(a_rearm_to_start, clk, rst, cmd.rearm, status.phase == PH_SIG && stream.ready, "decoder not back at signature after end of file")

endmodule
